### design/trapezoid_motion_profile_macros.svh
// assertion macros for the trapezoid motion profile block
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TMP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmp assertion failed");

// next-cycle implication, checked outside reset
`define TMP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmp assertion failed");

`endif

### design/tmp_pkg.sv
// shared types and constants of the trapezoid motion profile block
package tmp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 31;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 33;
    localparam int PROD_W    = 62;
    localparam int SQ_W      = PROD_W - FRAC_BITS;
    localparam int DIV_W     = 48;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = 3;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] IDX_ACCEL  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_CRUISE = 3'd1;
    localparam logic [IDX_W-1:0] IDX_DIST   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_START  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_END    = 3'd4;

    // reset profile: accel 1.0, cruise 1.0, zero distance
    localparam logic [VAL_W-1:0] RST_ACCEL  = 31'd65536;
    localparam logic [VAL_W-1:0] RST_CRUISE = 31'd65536;
    localparam logic [VAL_W-1:0] RST_SEG_A  = 31'd65536;
    localparam logic [VAL_W-1:0] RST_SEG_D  = 31'd65536;
    localparam logic [VAL_W-1:0] RST_DIST_A = 31'd32768;
    localparam logic [SUM_W-1:0] RST_T2     = 33'd65536;
    localparam logic [SUM_W-1:0] RST_TT     = 33'd131072;

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DECEL  = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // configuration and derived segment data
    typedef struct packed {
        logic [VAL_W-1:0] accel;
        logic [VAL_W-1:0] vmax;
        logic [VAL_W-1:0] move_dist;
        logic [VAL_W-1:0] vstart;
        logic [VAL_W-1:0] vend;
        logic [VAL_W-1:0] seg_a;
        logic [VAL_W-1:0] dist_a;
        logic [SUM_W-1:0] t2;
        logic [SUM_W-1:0] tt;
        logic             err;
    } prof_cfg_t;

    // classified item between front and back
    typedef struct packed {
        phase_t           phase;
        logic [VAL_W-1:0] op_a;
        logic [VAL_W-1:0] op_sq;
        logic [VAL_W-1:0] op_lin;
    } item_t;

    function automatic logic [VAL_W-1:0] sat_val(input logic [63:0] v);
        logic [VAL_W-1:0] r;
        r = (v > 64'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
        return r;
    endfunction

endpackage

### design/tmp_in_if.sv
// input channel: one time point per item
interface tmp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_point;

    modport source (output valid, output time_point, input ready);
    modport sink (input valid, input time_point, output ready);
endinterface

### design/tmp_out_if.sv
// output channel: one profile sample per item
interface tmp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] accel_out;
    logic [30:0] velocity_out;
    logic [30:0] position_out;
    logic [2:0]  phase;
    logic [30:0] total_time;
    logic        profile_error;

    modport source (output valid, output accel_out, output velocity_out,
                    output position_out, output phase, output total_time,
                    output profile_error, input ready);
    modport sink (input valid, input accel_out, input velocity_out,
                  input position_out, input phase, input total_time,
                  input profile_error, output ready);
endinterface

### design/tmp_derive.sv
// configuration registers and segment time derivation with a shared divider
module tmp_derive
    import tmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0] cfg_data,
    output prof_cfg_t        cfg,
    output logic             busy
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK0 = 9'b000000010,
        ST_DIV_A  = 9'b000000100,
        ST_DIV_D  = 9'b000001000,
        ST_MUL_A  = 9'b000010000,
        ST_MUL_D  = 9'b000100000,
        ST_CHECK1 = 9'b001000000,
        ST_DIV_C  = 9'b010000000,
        ST_FIN    = 9'b100000000
    } dstate_t;

    dstate_t          state_reg;
    logic [VAL_W-1:0] accel_reg, vmax_reg, dist_reg, vs_reg, ve_reg;
    logic [VAL_W-1:0] seg_a_reg, seg_c_reg, seg_d_reg, dist_a_reg;
    logic [SUM_W-1:0] t2_reg, tt_reg;
    logic             err_reg;
    logic [DIV_W-1:0] num_reg;
    logic [VAL_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SQ_W-1:0]  da_full_reg, dd_full_reg;

    logic [VAL_W-1:0] den;
    logic [VAL_W:0]   trial;
    logic             ge;
    logic [VAL_W-1:0] rem_step;
    logic [DIV_W-1:0] num_step;
    logic [VAL_W-1:0] q_sat;
    logic             div_last;
    logic [VAL_W:0]   mul_a;
    logic [VAL_W-1:0] mul_b;
    logic [62:0]      prod;
    logic [SQ_W-1:0]  dist_ext;
    logic             too_short;
    logic [SQ_W-1:0]  cruise_dist;

    // restoring divider step, one quotient bit per cycle
    always_comb
    begin
        den      = (state_reg == ST_DIV_C) ? vmax_reg : accel_reg;
        trial    = {rem_reg, num_reg[DIV_W-1]};
        ge       = trial >= {1'b0, den};
        rem_step = ge ? VAL_W'(trial - {1'b0, den}) : trial[VAL_W-1:0];
        num_step = {num_reg[DIV_W-2:0], ge};
        q_sat    = (|num_step[DIV_W-1:VAL_W]) ? VAL_MAX : num_step[VAL_W-1:0];
        div_last = cnt_reg == CNT_W'(DIV_W - 1);
    end

    // shared multiplier for the ramp distances
    always_comb
    begin
        mul_a = (state_reg == ST_MUL_A) ? ({1'b0, vs_reg} + {1'b0, vmax_reg})
                                        : ({1'b0, ve_reg} + {1'b0, vmax_reg});
        mul_b = (state_reg == ST_MUL_A) ? seg_a_reg : seg_d_reg;
        prod  = 63'(mul_a) * 63'(mul_b);
    end

    // distance check before the cruise division
    always_comb
    begin
        dist_ext    = SQ_W'(dist_reg);
        too_short   = (da_full_reg > dist_ext) || (dd_full_reg > dist_ext - da_full_reg);
        cruise_dist = dist_ext - da_full_reg - dd_full_reg;
    end

    // register file and derivation sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            accel_reg   <= RST_ACCEL;
            vmax_reg    <= RST_CRUISE;
            dist_reg    <= '0;
            vs_reg      <= '0;
            ve_reg      <= '0;
            seg_a_reg   <= RST_SEG_A;
            seg_c_reg   <= '0;
            seg_d_reg   <= RST_SEG_D;
            dist_a_reg  <= RST_DIST_A;
            t2_reg      <= RST_T2;
            tt_reg      <= RST_TT;
            err_reg     <= 1'b1;
            num_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            da_full_reg <= '0;
            dd_full_reg <= '0;
        end
        else if (cfg_we && (cfg_index <= IDX_END))
        begin
            case (cfg_index)
                IDX_ACCEL:  accel_reg <= cfg_data;
                IDX_CRUISE: vmax_reg  <= cfg_data;
                IDX_DIST:   dist_reg  <= cfg_data;
                IDX_START:  vs_reg    <= cfg_data;
                default:    ve_reg    <= cfg_data;
            endcase
            state_reg <= ST_CHECK0;
        end
        else
        begin
            case (state_reg)
                ST_CHECK0:
                begin
                    seg_a_reg  <= '0;
                    seg_c_reg  <= '0;
                    seg_d_reg  <= '0;
                    dist_a_reg <= '0;
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    if ((accel_reg == '0) || (vmax_reg == '0))
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        err_reg <= (vs_reg > vmax_reg) || (ve_reg > vmax_reg);
                        num_reg <= (vs_reg <= vmax_reg)
                                   ? {1'b0, vmax_reg - vs_reg, 16'b0} : '0;
                        state_reg <= ST_DIV_A;
                    end
                end
                ST_DIV_A:
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        seg_a_reg <= q_sat;
                        num_reg   <= (ve_reg <= vmax_reg)
                                     ? {1'b0, vmax_reg - ve_reg, 16'b0} : '0;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_D;
                    end
                end
                ST_DIV_D:
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        seg_d_reg <= q_sat;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A:
                begin
                    da_full_reg <= prod[62:FRAC_BITS+1];
                    state_reg   <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    dd_full_reg <= prod[62:FRAC_BITS+1];
                    state_reg   <= ST_CHECK1;
                end
                ST_CHECK1:
                begin
                    dist_a_reg <= da_full_reg[VAL_W-1:0];
                    rem_reg    <= '0;
                    cnt_reg    <= '0;
                    num_reg    <= {1'b0, cruise_dist[VAL_W-1:0], 16'b0};
                    if (too_short)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else if (err_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_C;
                    end
                end
                ST_DIV_C:
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                    begin
                        seg_c_reg <= q_sat;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    t2_reg    <= SUM_W'(seg_a_reg) + SUM_W'(seg_c_reg);
                    tt_reg    <= SUM_W'(seg_a_reg) + SUM_W'(seg_c_reg) + SUM_W'(seg_d_reg);
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // profile view for the datapath
    always_comb
    begin
        cfg.accel     = accel_reg;
        cfg.vmax      = vmax_reg;
        cfg.move_dist = dist_reg;
        cfg.vstart    = vs_reg;
        cfg.vend      = ve_reg;
        cfg.seg_a     = seg_a_reg;
        cfg.dist_a    = dist_a_reg;
        cfg.t2        = t2_reg;
        cfg.tt        = tt_reg;
        cfg.err       = err_reg;
        busy          = state_reg != ST_IDLE;
    end

endmodule

### design/tmp_front.sv
// front end: accepts time points, classifies the phase, queues items
module tmp_front
    import tmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tmp_in_if.sink     in_ch,
    input  prof_cfg_t  cfg,
    input  logic       busy,
    input  logic       q_pop,
    output logic       q_valid,
    output item_t      q_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    item_t            fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    item_t            cls;
    logic [SUM_W-1:0] t_ext;
    logic             push;

    // phase classification against the segment boundaries
    always_comb
    begin
        t_ext      = SUM_W'(in_ch.time_point[VAL_W-1:0]);
        cls.phase  = PH_DONE;
        cls.op_a   = '0;
        cls.op_sq  = '0;
        cls.op_lin = '0;
        if (in_ch.time_point[TIME_W-1])
        begin
            cls.phase = PH_BEFORE;
        end
        else if (t_ext < SUM_W'(cfg.seg_a))
        begin
            cls.phase  = PH_ACCEL;
            cls.op_a   = t_ext[VAL_W-1:0];
            cls.op_sq  = t_ext[VAL_W-1:0];
            cls.op_lin = t_ext[VAL_W-1:0];
        end
        else if (t_ext < cfg.t2)
        begin
            cls.phase  = PH_CRUISE;
            cls.op_lin = VAL_W'(t_ext - SUM_W'(cfg.seg_a));
        end
        else if (t_ext < cfg.tt)
        begin
            cls.phase = PH_DECEL;
            cls.op_a  = VAL_W'(t_ext - cfg.t2);
            cls.op_sq = VAL_W'(cfg.tt - t_ext);
        end
    end

    assign in_ch.ready = !busy && (count_reg != (PTR_W+1)'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = count_reg != '0;
    assign q_item      = fifo_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/tmp_back.sv
// back end: three-stage multiply pipeline that forms velocity and position
module tmp_back
    import tmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    input  prof_cfg_t  cfg,
    tmp_out_if.source  out_ch
);

    localparam int HALF = SQ_W / 2;

    logic             en;
    logic             v1_reg, v2_reg, v3_reg;
    phase_t           ph1_reg, ph2_reg, ph3_reg;
    logic [SQ_W-1:0]  av_reg, sq_reg, lin1_reg, lin2_reg;
    logic [VAL_W-1:0] vel2_reg, vel3_reg, pos3_reg;
    logic [VAL_W+HALF-1:0] plo_reg, phi_reg;
    logic [VAL_W-1:0] coef;
    logic [PROD_W-1:0] m_av, m_sq, m_lin;
    logic [SQ_W:0]    vsum;
    logic [VAL_W-1:0] vel_n;
    logic [77:0]      dp_full;
    logic [60:0]      dp;
    logic [VAL_W-1:0] pos_n;

    assign en    = !v3_reg || out_ch.ready;
    assign q_pop = en && q_valid;

    // stage one products
    always_comb
    begin
        coef  = (q_item.phase == PH_ACCEL) ? cfg.vstart : cfg.vmax;
        m_av  = PROD_W'(cfg.accel) * PROD_W'(q_item.op_a);
        m_sq  = PROD_W'(q_item.op_sq) * PROD_W'(q_item.op_sq);
        m_lin = PROD_W'(coef) * PROD_W'(q_item.op_lin);
    end

    // stage two velocity
    always_comb
    begin
        vsum = (SQ_W+1)'(cfg.vstart) + (SQ_W+1)'(av_reg);
        case (ph1_reg)
            PH_ACCEL:  vel_n = sat_val(64'(vsum));
            PH_CRUISE: vel_n = cfg.vmax;
            PH_DECEL:  vel_n = (av_reg > SQ_W'(cfg.vmax)) ? '0
                               : VAL_W'(SQ_W'(cfg.vmax) - av_reg);
            PH_BEFORE: vel_n = cfg.vstart;
            default:   vel_n = cfg.vend;
        endcase
    end

    // stage three position
    always_comb
    begin
        dp_full = {phi_reg, {HALF{1'b0}}} + 78'(plo_reg);
        dp      = dp_full[77:FRAC_BITS+1];
        case (ph2_reg)
            PH_ACCEL:  pos_n = sat_val(64'(dp) + 64'(lin2_reg));
            PH_CRUISE: pos_n = sat_val(64'(cfg.dist_a) + 64'(lin2_reg));
            PH_DECEL:  pos_n = (dp > 61'(cfg.move_dist)) ? '0
                               : VAL_W'(61'(cfg.move_dist) - dp);
            PH_BEFORE: pos_n = '0;
            default:   pos_n = cfg.move_dist;
        endcase
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph1_reg  <= q_item.phase;
            av_reg   <= m_av[PROD_W-1:FRAC_BITS];
            sq_reg   <= m_sq[PROD_W-1:FRAC_BITS];
            lin1_reg <= m_lin[PROD_W-1:FRAC_BITS];
            ph2_reg  <= ph1_reg;
            vel2_reg <= vel_n;
            lin2_reg <= lin1_reg;
            plo_reg  <= (VAL_W+HALF)'(cfg.accel) * (VAL_W+HALF)'(sq_reg[HALF-1:0]);
            phi_reg  <= (VAL_W+HALF)'(cfg.accel) * (VAL_W+HALF)'(sq_reg[SQ_W-1:HALF]);
            ph3_reg  <= ph2_reg;
            vel3_reg <= vel2_reg;
            pos3_reg <= pos_n;
        end
    end

    // output register drive
    always_comb
    begin
        out_ch.valid         = v3_reg;
        out_ch.velocity_out  = vel3_reg;
        out_ch.position_out  = pos3_reg;
        out_ch.phase         = ph3_reg;
        out_ch.total_time    = sat_val(64'(cfg.tt));
        out_ch.profile_error = cfg.err;
        case (ph3_reg)
            PH_ACCEL: out_ch.accel_out = {1'b0, cfg.accel};
            PH_DECEL: out_ch.accel_out = ~{1'b0, cfg.accel} + 32'd1;
            default:  out_ch.accel_out = '0;
        endcase
    end

endmodule

### design/trapezoid_motion_profile.sv
// top level: accepted items pass the front queue and the back-end pipeline registers
// throughput: one item per cycle while the receiver is ready and no derivation runs;
// a front queue of four decouples the multiply pipeline; a configuration write
// starts a segment derivation through one shared restoring divider, input ready
// is low meanwhile; reset (rst_n, async, active low) loads accel 1.0, cruise 1.0
// and the derived profile at once, so items are taken right after reset
`include "trapezoid_motion_profile_macros.svh"

module trapezoid_motion_profile
    import tmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tmp_in_if.sink           in_ch,
    tmp_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0] cfg_data
);

    prof_cfg_t cfg;
    logic      busy;
    logic      q_valid;
    logic      q_pop;
    item_t     q_item;
    logic      flat_phase;

    // segment derivation
    tmp_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy)
    );

    // accept and classify
    tmp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .cfg     (cfg),
        .busy    (busy),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    // evaluate
    tmp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .out_ch  (out_ch)
    );

    // result phases with no acceleration
    assign flat_phase = (out_ch.phase == PH_CRUISE) || (out_ch.phase == PH_BEFORE)
                        || (out_ch.phase == PH_DONE);

    // checks
    `TMP_ASSERT_NEXT(a_cfg_starts_derive, cfg_we && (cfg_index <= IDX_END), busy)
    `TMP_ASSERT_NOW(a_no_accept_while_busy, busy, !in_ch.ready)
    `TMP_ASSERT_NOW(a_flat_accel, out_ch.valid && flat_phase, out_ch.accel_out == '0)

endmodule

### tb/tb_trapezoid_motion_profile.sv
// testbench for the trapezoid motion profile block: directed and random time points
`timescale 1ns / 100ps

module tb_trapezoid_motion_profile;
    import tmp_pkg::*;

    localparam int        IDLE_LIMIT = 20000;
    localparam int        HOLD_CYCLES = 300;
    localparam logic [63:0] SAT31 = 64'h7FFF_FFFF;

    typedef struct {
        logic [31:0] accel;
        logic [30:0] vel;
        logic [30:0] pos;
        phase_t      phase;
        logic [30:0] total;
        logic        err;
    } sample_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0] cfg_data;

    tmp_in_if  in_ch ();
    tmp_out_if out_ch ();

    trapezoid_motion_profile dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // profile registers and derived segments
    logic [63:0] p_accel, p_vmax, p_dist, p_vstart, p_vend;
    logic [63:0] t_acc, t_cru, t_dec, d_acc;
    logic        p_err;

    sample_t expected_samples[$];
    int      error_count;
    int      idle_cycles;
    bit      hold_request;
    int      burst_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // floor(x*y / 2^s), saturated to 64 bits
    function automatic logic [63:0] mul_shr(input logic [63:0] x, input logic [63:0] y,
                                            input int s);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        p = p >> s;
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [30:0] clip31(input logic [63:0] v);
        return (v > SAT31) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    // segment times from the registers
    task automatic derive_segments();
        logic [63:0] dd;
        t_acc = 0; t_cru = 0; t_dec = 0; d_acc = 0;
        p_err = 1'b0;
        if (p_accel == 0 || p_vmax == 0)
        begin
            p_err = 1'b1;
            return;
        end
        if (p_vstart > p_vmax || p_vend > p_vmax)
            p_err = 1'b1;
        if (p_vstart <= p_vmax)
            t_acc = ((p_vmax - p_vstart) << FRAC_BITS) / p_accel;
        if (p_vend <= p_vmax)
            t_dec = ((p_vmax - p_vend) << FRAC_BITS) / p_accel;
        if (t_acc > SAT31) t_acc = SAT31;
        if (t_dec > SAT31) t_dec = SAT31;
        d_acc = mul_shr(p_vstart + p_vmax, t_acc, FRAC_BITS + 1);
        dd = mul_shr(p_vend + p_vmax, t_dec, FRAC_BITS + 1);
        if (d_acc > p_dist || dd > p_dist - d_acc)
        begin
            p_err = 1'b1;
            return;
        end
        if (!p_err)
        begin
            t_cru = ((p_dist - d_acc - dd) << FRAC_BITS) / p_vmax;
            if (t_cru > SAT31) t_cru = SAT31;
        end
    endtask

    function automatic sample_t profile_at(input logic [31:0] tp);
        sample_t     s;
        logic [63:0] t, t1, t2, tt, vel, pos, dv, r, dp;
        t1 = t_acc;
        t2 = t_acc + t_cru;
        tt = t2 + t_dec;
        t = {32'd0, tp};
        s.accel = 32'd0;
        if (tp[31])
        begin
            s.phase = PH_BEFORE;
            vel = p_vstart;
            pos = 0;
        end
        else if (t < t1)
        begin
            s.phase = PH_ACCEL;
            s.accel = p_accel[31:0];
            vel = add_clip(p_vstart, mul_shr(p_accel, t, FRAC_BITS));
            pos = add_clip(mul_shr(p_vstart, t, FRAC_BITS),
                           mul_shr(p_accel, mul_shr(t, t, FRAC_BITS), FRAC_BITS + 1));
        end
        else if (t < t2)
        begin
            s.phase = PH_CRUISE;
            vel = p_vmax;
            pos = add_clip(d_acc, mul_shr(p_vmax, t - t1, FRAC_BITS));
        end
        else if (t < tt)
        begin
            s.phase = PH_DECEL;
            s.accel = 32'd0 - p_accel[31:0];
            dv = mul_shr(p_accel, t - t2, FRAC_BITS);
            r = tt - t;
            dp = mul_shr(p_accel, mul_shr(r, r, FRAC_BITS), FRAC_BITS + 1);
            vel = (dv > p_vmax) ? 0 : p_vmax - dv;
            pos = (dp > p_dist) ? 0 : p_dist - dp;
        end
        else
        begin
            s.phase = PH_DONE;
            vel = p_vend;
            pos = p_dist;
        end
        s.vel = clip31(vel);
        s.pos = clip31(pos);
        s.total = clip31(tt);
        s.err = p_err;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // append one prediction at the tail of the expected queue
    task automatic enqueue_expected(input sample_t s);
        expected_samples.insert(expected_samples.size(), s);
    endtask

    // predict on input accept, check on output accept
    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                enqueue_expected(profile_at(in_ch.time_point));
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("unexpected item", 0, 0);
                else
                begin
                    e = expected_samples.pop_front();
                    if (out_ch.accel_out !== e.accel)
                        report_mismatch("accel_out", out_ch.accel_out, e.accel);
                    if (out_ch.velocity_out !== e.vel)
                        report_mismatch("velocity_out", out_ch.velocity_out, e.vel);
                    if (out_ch.position_out !== e.pos)
                        report_mismatch("position_out", out_ch.position_out, e.pos);
                    if (out_ch.phase !== e.phase)
                        report_mismatch("phase", out_ch.phase, e.phase);
                    if (out_ch.total_time !== e.total)
                        report_mismatch("total_time", out_ch.total_time, e.total);
                    if (out_ch.profile_error !== e.err)
                        report_mismatch("profile_error", out_ch.profile_error, e.err);
                end
            end
        end
    end

    // receiver stall pattern with an occasional long hold-off
    initial
    begin
        int mode;
        int span;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= $urandom_range(0, 1);
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no accept and no register write
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_trapezoid_motion_profile: errors");
            $finish;
        end
    end

    // one item, bursts of random length with random gaps
    task automatic send_point(input logic [31:0] tp);
        in_ch.valid <= 1'b1;
        in_ch.time_point <= tp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 2) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // register write while idle, then wait out the derivation
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            IDX_ACCEL:  p_accel = val;
            IDX_CRUISE: p_vmax = val;
            IDX_DIST:   p_dist = val;
            IDX_START:  p_vstart = val;
            IDX_END:    p_vend = val;
            default: ;
        endcase
        derive_segments();
        repeat (3) @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_profile(input logic [30:0] a, input logic [30:0] vm,
                                input logic [30:0] d, input logic [30:0] vs,
                                input logic [30:0] ve);
        write_reg(IDX_ACCEL, a);
        write_reg(IDX_CRUISE, vm);
        write_reg(IDX_DIST, d);
        write_reg(IDX_START, vs);
        write_reg(IDX_END, ve);
    endtask

    function automatic logic [31:0] clip_time(input logic [63:0] t);
        return (t > SAT31) ? 32'h7FFF_FFFF : t[31:0];
    endfunction

    // boundaries of every phase plus the field extremes
    task automatic test_boundaries();
        logic [63:0] b[3];
        b[0] = t_acc;
        b[1] = t_acc + t_cru;
        b[2] = b[1] + t_dec;
        send_point(32'h8000_0000);
        send_point(32'hFFFF_FFFF);
        send_point(32'h0000_0000);
        send_point(32'h7FFF_FFFF);
        foreach (b[i])
        begin
            if (b[i] != 0)
                send_point(clip_time(b[i] - 1));
            send_point(clip_time(b[i]));
            send_point(clip_time(b[i] + 1));
        end
    endtask

    task automatic test_directed();
        // reset profile, then a regular trapezoid
        test_boundaries();
        load_profile(31'h0002_0000, 31'h0003_0000, 31'h0010_0000, 31'h0000_8000, 31'h0001_0000);
        test_boundaries();
        // distance too short for a trapezoid
        load_profile(31'h0001_0000, 31'h0004_0000, 31'h0002_0000, 31'd0, 31'd0);
        test_boundaries();
        // start speed above cruise, then end speed above cruise
        load_profile(31'h0001_0000, 31'h0001_0000, 31'h0100_0000, 31'h0002_0000, 31'd0);
        test_boundaries();
        load_profile(31'h0001_0000, 31'h0001_0000, 31'h0100_0000, 31'd0, 31'h0002_0000);
        test_boundaries();
        // zero acceleration, then zero cruise speed
        load_profile(31'd0, 31'h0001_0000, 31'h0010_0000, 31'd0, 31'd0);
        test_boundaries();
        load_profile(31'h0001_0000, 31'd0, 31'h0010_0000, 31'd0, 31'd0);
        test_boundaries();
        // extremes: slowest acceleration, largest everything, out of range index
        load_profile(31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd0);
        test_boundaries();
        load_profile(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        test_boundaries();
        write_reg(3'd5, 31'h1234_5678);
        write_reg(3'd7, 31'h7FFF_FFFF);
        test_boundaries();
    endtask

    // receiver holds off while items keep coming
    task automatic test_backpressure();
        load_profile(31'h0002_0000, 31'h0004_0000, 31'h0040_0000, 31'd0, 31'h0001_0000);
        drain();
        hold_request = 1'b1;
        // wait until the receiver has started its hold-off
        while (hold_request)
            @(posedge clk);
        burst_left = 1000;
        repeat (40) send_point($urandom_range(0, 32'h0008_0000));
        burst_left = 0;
    endtask

    // random profiles, mostly well formed, with points spread over the move
    task automatic test_random();
        logic [30:0] a, vm, vs, ve, d;
        logic [63:0] tt;
        logic [31:0] tp;
        int          k;
        repeat (12)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                a = $urandom; vm = $urandom; d = $urandom; vs = $urandom; ve = $urandom;
            end
            else
            begin
                a = $urandom_range(31'h0000_1000, 31'h0010_0000);
                vm = $urandom_range(31'h0000_4000, 31'h0010_0000);
                vs = $urandom_range(0, vm);
                ve = $urandom_range(0, vm);
                d = $urandom_range(0, 31'h7FFF_FFFF);
            end
            load_profile(a, vm, d, vs, ve);
            tt = t_acc + t_cru + t_dec;
            repeat (98)
            begin
                k = $urandom_range(0, 9);
                if (k < 2)
                    tp = $urandom;
                else if (k < 4)
                    tp = clip_time(((k == 2) ? t_acc : t_acc + t_cru)
                                   + $urandom_range(0, 6)) - 3;
                else
                    tp = $urandom_range(0, clip_time(tt + 16));
                send_point(tp);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.time_point = '0;
        hold_request = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        p_accel = 65536; p_vmax = 65536; p_dist = 0; p_vstart = 0; p_vend = 0;
        derive_segments();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();
        drain();

        if (error_count == 0)
            $display("tb_trapezoid_motion_profile: clean");
        else
            $display("tb_trapezoid_motion_profile: errors");
        $finish;
    end

endmodule
